// ===== rtl/core/pbag_pkg.sv =====
package pbag_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CFG_W    = 20;
  localparam int unsigned RETRY_W  = 22;
  localparam int unsigned INDEX_W  = 2;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // The backoff never exceeds twice a 20-bit cap, so 21 bits hold it.
  localparam int unsigned BACKOFF_W = CFG_W + 1;

  // Configuration reset values.
  localparam logic [CFG_W-1:0] MIN_GAP_RST      = CFG_W'(5000);
  localparam logic [CFG_W-1:0] INIT_BACKOFF_RST = CFG_W'(10000);
  localparam logic [CFG_W-1:0] MAX_BACKOFF_RST  = CFG_W'(300000);

  // floor(x / 1000) for x below 2^31 is floor(x * RECIP_1000 / 2^41).
  localparam int unsigned      DIFF_W      = TIME_W - 1;
  localparam int unsigned      RECIP_W     = 32;
  localparam int unsigned      RECIP_SHIFT = 41;
  localparam int unsigned      PROD_W      = DIFF_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 32'd2199023256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_GAP      = 2'd0,
    CFG_INIT_BACKOFF = 2'd1,
    CFG_MAX_BACKOFF  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [ADDR_W-1:0] peer_addr;
    logic [TIME_W-1:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic               admitted;
    logic [RETRY_W-1:0] retry_after_s;
    logic [INDEX_W-1:0] entry_index;
    logic [COUNT_W-1:0] reject_total;
  } out_word_t;

endpackage

// ===== rtl/core/peer_backoff_admission_guard.sv =====
// Per-peer exponential backoff admission guard. Each input word is one
// connection attempt (peer address and a wrapping millisecond time) and
// produces exactly one result word: admit, or reject with a retry-after
// value in whole seconds, plus the table entry used and that entry's reject
// count. The block sustains one word per clock cycle. Each accepted word
// sits in the input register while the table compare, the entry update
// and the reciprocal multiply that turns the remaining cooldown into
// seconds run, and the result register captures the outcome when the
// input register advances. The input only stalls while both registers
// are full and the result is held. The peer table holds PEER_SLOTS entries
// in flip-flops with a valid bit each, cleared at reset, so no clearing
// pass is needed. Configuration writes are always ready and must only be
// issued while no attempt is in flight.
module peer_backoff_admission_guard #(
  parameter int unsigned PEER_SLOTS = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  pbag_pkg::in_word_t                  in_word_i,

  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output pbag_pkg::out_word_t                 out_word_o,

  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pbag_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pbag_pkg::CFG_W-1:0]          cfg_data_i
);

  localparam int unsigned IDX_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;

  // Configuration registers.
  logic [pbag_pkg::CFG_W-1:0] min_gap_q, init_backoff_q, max_backoff_q;

  // Peer table. The valid bits gate every lookup, so the payload arrays
  // need no reset.
  logic [PEER_SLOTS-1:0]               vld_q;
  logic [pbag_pkg::ADDR_W-1:0]         addr_q     [PEER_SLOTS];
  logic [pbag_pkg::TIME_W-1:0]         last_q     [PEER_SLOTS];
  logic [pbag_pkg::TIME_W-1:0]         cool_q     [PEER_SLOTS];
  logic [pbag_pkg::BACKOFF_W-1:0]      backoff_q  [PEER_SLOTS];
  logic [pbag_pkg::COUNT_W-1:0]        rejects_q  [PEER_SLOTS];
  logic [IDX_W-1:0]                    ptr_q, ptr_d;

  // Input register and result register.
  logic                 in_valid_q;
  pbag_pkg::in_word_t   in_word_q;
  logic                 out_valid_q;
  pbag_pkg::out_word_t  out_word_q, out_word_d;

  logic in_load, advance;

  // The input register moves on whenever the result register is free or
  // being emptied in this cycle; it only stalls behind a held result.
  assign advance     = in_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o  = in_valid_q && out_valid_q && out_stall_i;
  assign in_load     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Lookup: at most one valid entry ever holds a given address, since a
  // peer is only inserted after missing.
  logic             hit;
  logic [IDX_W-1:0] hit_idx;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = PEER_SLOTS - 1; i >= 0; i--) begin
      if (vld_q[i] && (addr_q[i] == in_word_q.peer_addr)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  // Decision and next entry contents.
  logic [pbag_pkg::TIME_W-1:0]    now, cool_cur, last_cur, since_last, cool_diff;
  logic [pbag_pkg::TIME_W-1:0]    cool_new, diff;
  logic [pbag_pkg::BACKOFF_W-1:0] bo_cur, bo_new;
  logic [pbag_pkg::COUNT_W-1:0]   rej_cur, rej_new;
  logic                           cooling, violation, reject, retry_ahead;
  logic [IDX_W-1:0]               wr_idx;
  logic [pbag_pkg::PROD_W-1:0]    prod;
  logic [pbag_pkg::RETRY_W-1:0]   retry;

  assign now        = in_word_q.now_ms;
  assign cool_cur   = cool_q[hit_idx];
  assign last_cur   = last_q[hit_idx];
  assign bo_cur     = backoff_q[hit_idx];
  assign rej_cur    = rejects_q[hit_idx];

  // Cooldown still running: signed difference of end and now is positive.
  assign cool_diff  = cool_cur - now;
  assign cooling    = (cool_diff != '0) && !cool_diff[pbag_pkg::TIME_W-1];
  assign since_last = now - last_cur;
  assign violation  = since_last < pbag_pkg::TIME_W'(min_gap_q);
  assign reject     = hit && (cooling || violation);

  // A gap violation restarts the cooldown at now plus the current backoff,
  // so the remaining time is just that backoff.
  assign cool_new = violation ? (now + pbag_pkg::TIME_W'(bo_cur)) : cool_cur;
  assign diff     = violation ? pbag_pkg::TIME_W'(bo_cur) : cool_diff;
  assign retry_ahead = (diff != '0) && !diff[pbag_pkg::TIME_W-1];

  // Doubling only happens below the 20-bit cap, so the top bit is zero.
  assign bo_new  = (bo_cur < pbag_pkg::BACKOFF_W'(max_backoff_q)) ?
                   {bo_cur[pbag_pkg::BACKOFF_W-2:0], 1'b0} :
                   pbag_pkg::BACKOFF_W'(max_backoff_q);
  assign rej_new = rej_cur + 1'b1;

  // Whole seconds of remaining cooldown by reciprocal multiplication.
  assign prod  = pbag_pkg::PROD_W'(diff[pbag_pkg::DIFF_W-1:0]) *
                 pbag_pkg::PROD_W'(pbag_pkg::RECIP_1000);
  assign retry = retry_ahead ?
                 (prod[pbag_pkg::RECIP_SHIFT +: pbag_pkg::RETRY_W] + 1'b1) :
                 pbag_pkg::RETRY_W'(1);

  assign wr_idx = hit ? hit_idx : ptr_q;

  always_comb begin
    if (ptr_q == IDX_W'(PEER_SLOTS - 1)) begin
      ptr_d = '0;
    end else begin
      ptr_d = ptr_q + 1'b1;
    end
  end

  always_comb begin
    out_word_d.entry_index = pbag_pkg::INDEX_W'(wr_idx);
    if (reject) begin
      out_word_d.admitted      = 1'b0;
      out_word_d.retry_after_s = retry;
      out_word_d.reject_total  = rej_new;
    end else begin
      out_word_d.admitted      = 1'b1;
      out_word_d.retry_after_s = '0;
      out_word_d.reject_total  = hit ? rej_cur : '0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      vld_q          <= '0;
      ptr_q          <= '0;
      min_gap_q      <= pbag_pkg::MIN_GAP_RST;
      init_backoff_q <= pbag_pkg::INIT_BACKOFF_RST;
      max_backoff_q  <= pbag_pkg::MAX_BACKOFF_RST;
    end else begin
      if (in_load) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end

      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (advance && !hit) begin
        vld_q[ptr_q] <= 1'b1;
        ptr_q        <= ptr_d;
      end

      if (cfg_valid_i) begin
        case (cfg_index_i)
          pbag_pkg::CFG_MIN_GAP:      min_gap_q      <= cfg_data_i;
          pbag_pkg::CFG_INIT_BACKOFF: init_backoff_q <= cfg_data_i;
          pbag_pkg::CFG_MAX_BACKOFF:  max_backoff_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_word_q <= in_word_i;
    end
    if (advance) begin
      out_word_q <= out_word_d;
      if (reject) begin
        last_q[wr_idx]    <= now;
        rejects_q[wr_idx] <= rej_new;
        if (violation) begin
          cool_q[wr_idx]    <= cool_new;
          backoff_q[wr_idx] <= bo_new;
        end
      end else begin
        addr_q[wr_idx]    <= in_word_q.peer_addr;
        last_q[wr_idx]    <= now;
        backoff_q[wr_idx] <= pbag_pkg::BACKOFF_W'(init_backoff_q);
        if (!hit) begin
          cool_q[wr_idx]    <= '0;
          rejects_q[wr_idx] <= '0;
        end
      end
    end
  end

endmodule

// ===== rtl/core/pbag_chk.sv =====
module pbag_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input pbag_pkg::out_word_t out_word_o
);

  // A held result word does not change.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // Admits carry no retry time, rejects always carry at least one second.
  a_retry_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.admitted == (out_word_o.retry_after_s == '0)))
    else $error("retry_after_s does not match the admit decision");

  // The input side only stalls behind a held result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // A result appearing on an empty output comes from a word that was
  // accepted into the input register and passed on without a stall.
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a matching accepted word");

endmodule

bind peer_backoff_admission_guard pbag_chk u_pbag_chk (.*);
